/* rtl/rrq_pkg.sv */
package rrq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROTATE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

/* rtl/rrq_ram.sv */
module rrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/round_robin_run_queue_top.sv */
// Round-robin run queue: a bounded FIFO of process entries (id, remaining units, queue
// time, total time) kept in one entry memory with a head pointer and an entry count.
// Each request gives one result. Enqueue, dequeue and a one-entry rotate go through
// the finish state, which loads the result register; a rotate of more entries first
// passes a rotate state, and a tick a walk state that walks every stored entry one per
// cycle through the memory's single read and write ports. A new request is taken in the
// cycle after the last result was loaded, even while it is not yet taken. The user must
// write capacity on the configuration channel only while the queue is idle; the block
// does not enforce it. Values above the depth act as the depth, zero refuses enqueues.
module round_robin_run_queue_top #(
    parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF,
    parameter int COUNT_WIDTH = rrq_pkg::COUNT_WIDTH_DEF,
    parameter int ID_WIDTH    = rrq_pkg::ID_WIDTH_DEF,
    localparam int EW    = ID_WIDTH + 3 * COUNT_WIDTH,
    localparam int OW    = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_W  = ((EW + 7) / 8) * 8,
    localparam int OUT_W = ((EW + OW + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rrq_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // process_id, remaining_units, queue_time_in, total_time_in
    input  logic [IN_W-1:0]             s_axis_tdata,
    // cmd
    input  logic [rrq_pkg::CMD_W-1:0]   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // entry_id, entry_remaining, entry_queue_time, entry_total_time, occupancy
    output logic [OUT_W-1:0]            m_axis_tdata,
    // status, entry_valid
    output logic [rrq_pkg::STATUS_W:0]  m_axis_tuser
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = OW;

    localparam int REM_LO = ID_WIDTH;
    localparam int QT_LO  = ID_WIDTH + COUNT_WIDTH;
    localparam int TT_LO  = ID_WIDTH + 2 * COUNT_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROT  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_RAM  = 2'd1;
    localparam logic [1:0] SRC_HOLD = 2'd2;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [1:0]                     r_state, n_state;
    logic [AW-1:0]                  r_head, n_head;
    logic [CW-1:0]                  r_count, n_count;
    logic [rrq_pkg::CAP_W-1:0]      r_cap;
    logic [1:0]                     r_src, n_src;
    logic [rrq_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [AW-1:0]                  r_slot, n_slot;
    logic [CW-1:0]                  r_left, n_left;
    logic                           r_first, n_first;
    logic [EW-1:0]                  r_hold, n_hold;
    logic                           r_out_valid, n_out_valid;
    logic [rrq_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic                           r_out_ev, n_out_ev;
    logic [EW-1:0]                  r_out_entry, n_out_entry;
    logic [OW-1:0]                  r_out_occ, n_out_occ;

    logic                           ram_wr_en;
    logic [AW-1:0]                  ram_wr_addr;
    logic [EW-1:0]                  ram_wr_data;
    logic                           ram_rd_en;
    logic [AW-1:0]                  ram_rd_addr;
    logic [EW-1:0]                  ram_rd_data;

    logic                           in_req;
    logic                           out_free;
    logic                           is_full;
    logic [EW-1:0]                  in_entry;
    logic [EW-1:0]                  walk_entry;
    logic [COUNT_WIDTH-1:0]         w_rem, w_qt, w_tt;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    rrq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign in_entry      = s_axis_tdata[EW-1:0];
    assign is_full       = (32'(r_count) >= 32'(QUEUE_DEPTH)) || (32'(r_count) >= 32'(r_cap));

    // tick update of the entry coming back from memory
    always_comb begin
        w_rem = ram_rd_data[REM_LO +: COUNT_WIDTH];
        w_qt  = ram_rd_data[QT_LO +: COUNT_WIDTH];
        w_tt  = ram_rd_data[TT_LO +: COUNT_WIDTH];
        if (r_first && (w_rem != '0)) begin
            w_rem = w_rem - COUNT_WIDTH'(1);
        end
        if (w_qt != CNT_MAX) begin
            w_qt = w_qt + COUNT_WIDTH'(1);
        end
        if (w_tt != CNT_MAX) begin
            w_tt = w_tt + COUNT_WIDTH'(1);
        end
        walk_entry = {w_tt, w_qt, w_rem, ram_rd_data[ID_WIDTH-1:0]};
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_src        = r_src;
        n_status     = r_status;
        n_slot       = r_slot;
        n_left       = r_left;
        n_first      = r_first;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_ev     = r_out_ev;
        n_out_entry  = r_out_entry;
        n_out_occ    = r_out_occ;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_head;
        ram_wr_data  = in_entry;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_head;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_req) begin
                    n_state  = S_FIN;
                    n_status = rrq_pkg::STATUS_OK;
                    n_src    = SRC_RAM;
                    if (s_axis_tuser == rrq_pkg::CMD_ENQUEUE) begin
                        if (is_full) begin
                            n_status  = rrq_pkg::STATUS_FULL;
                            ram_rd_en = (r_count != '0);
                            n_src     = (r_count != '0) ? SRC_RAM : SRC_NONE;
                        end else begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = f_slot(r_head, r_count);
                            n_count     = r_count + CW'(1);
                            n_hold      = in_entry;
                            ram_rd_en   = (r_count != '0);
                            n_src       = (r_count != '0) ? SRC_RAM : SRC_HOLD;
                        end
                    end else if (r_count == '0) begin
                        n_status = rrq_pkg::STATUS_EMPTY;
                        n_src    = SRC_NONE;
                    end else begin
                        ram_rd_en = 1'b1;
                        case (s_axis_tuser)
                            rrq_pkg::CMD_DEQUEUE: begin
                                n_head  = f_slot(r_head, CW'(1));
                                n_count = r_count - CW'(1);
                            end
                            rrq_pkg::CMD_ROTATE: begin
                                if (r_count != CW'(1)) begin
                                    n_state = S_ROT;
                                end
                            end
                            rrq_pkg::CMD_TICK: begin
                                n_state = S_WALK;
                                n_slot  = r_head;
                                n_left  = r_count - CW'(1);
                                n_first = 1'b1;
                                n_src   = SRC_HOLD;
                            end
                            default: begin
                                n_state = S_FIN;
                            end
                        endcase
                    end
                end
            end
            S_ROT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = f_slot(r_head, r_count);
                ram_wr_data = ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = f_slot(r_head, CW'(1));
                n_head      = f_slot(r_head, CW'(1));
                n_state     = S_FIN;
            end
            S_WALK: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_slot;
                ram_wr_data = walk_entry;
                n_first     = 1'b0;
                if (r_first) begin
                    n_hold = walk_entry;
                end
                if (r_left != '0) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = f_slot(r_slot, CW'(1));
                    n_slot      = f_slot(r_slot, CW'(1));
                    n_left      = r_left - CW'(1);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_ev     = (r_src != SRC_NONE);
                    n_out_occ    = r_count;
                    case (r_src)
                        SRC_RAM:  n_out_entry = ram_rd_data;
                        SRC_HOLD: n_out_entry = r_hold;
                        default:  n_out_entry = '0;
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_cap       <= rrq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src        <= n_src;
        r_status     <= n_status;
        r_slot       <= n_slot;
        r_left       <= n_left;
        r_first      <= n_first;
        r_hold       <= n_hold;
        r_out_status <= n_out_status;
        r_out_ev     <= n_out_ev;
        r_out_entry  <= n_out_entry;
        r_out_occ    <= n_out_occ;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_occ, r_out_entry});
    assign m_axis_tuser  = {r_out_ev, r_out_status};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == rrq_pkg::STATUS_EMPTY)
        |-> !r_out_ev && (r_out_occ == '0))
        else $error("empty status with entries reported");

    a_no_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ev |-> (r_out_entry == '0))
        else $error("entry fields not cleared without an entry");

    a_dequeue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req && (s_axis_tuser == rrq_pkg::CMD_DEQUEUE) && (r_count != '0)
        |=> r_count == $past(r_count) - CW'(1))
        else $error("dequeue did not remove one entry");

endmodule
